### rtl/core/rmsb_pkg.sv
`default_nettype none

package rmsb_pkg;

    // Fixed field and state widths
    localparam int AXIS_W   = 16;
    localparam int MAG_W    = 17;
    localparam int SUM_W    = 37;
    localparam int IDX_W    = 7;
    localparam int CNT_W    = 5;
    localparam int N3_W     = 7;
    localparam int RMS_W    = 15;
    localparam int ROOT_W   = 16;
    localparam int RAD_W    = 32;
    localparam int REM_W    = 17;
    localparam int ALU_W    = 19;
    localparam int STEP_W   = 6;

    // Configuration port
    localparam int ADDR_W   = 3;
    localparam int DATA_W   = 32;
    localparam logic [ADDR_W-1:0] ADDR_SAMPLE_COUNT = 3'd0;
    localparam logic [CNT_W-1:0]  SAMPLE_COUNT_RST  = 5'd16;

    // Last step indices of the shared subtract unit
    localparam logic [STEP_W-1:0] DIV_LAST  = 6'(SUM_W - 1);
    localparam logic [STEP_W-1:0] SQRT_LAST = 6'(ROOT_W - 1);

    typedef logic [SUM_W-1:0]  t_sum;
    typedef logic [IDX_W-1:0]  t_idx;
    typedef logic [ALU_W-1:0]  t_alu;

endpackage

`default_nettype wire

### rtl/core/rms_over_sample_burst.sv
`default_nettype none

// RMS over a burst of interleaved x, y, z accelerometer words. Each burst drops its first
// DISCARD_VALUES words, then sums the exact squares of the next 3 x sample_count words and
// returns floor(sqrt(floor(sum / (3 x sample_count)))), saturated to 32767, before it rearms.
// A word with burst_start high restarts the count. sample_count (APB offset 0, reset 16)
// saturates to the range 1 .. FIFO_SAMPLES-3. A word that is not the last of a burst is
// accepted in S_IDLE, then squared (17 x 17) and accumulated in S_ACC before the next word is
// taken. After the last word of a burst, a single 19-bit subtract-and-compare unit first
// runs 37 restoring divide steps and then 16 digit-by-digit square root steps. A finished
// result waits in the output register while the next words are taken.
module rms_over_sample_burst #(
    parameter int FIFO_SAMPLES   = 32,
    parameter int DISCARD_VALUES = 9
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    // input words
    input  wire                                  i_valid,
    output logic                                 o_ready,
    input  wire signed [rmsb_pkg::AXIS_W-1:0]    i_axis_value,
    input  wire                                  i_burst_start,
    // results
    output logic                                 o_valid,
    input  wire                                  i_ready,
    output logic [rmsb_pkg::RMS_W-1:0]           o_rms_value,
    // configuration
    input  wire                                  psel,
    input  wire                                  penable,
    input  wire                                  pwrite,
    input  wire [rmsb_pkg::ADDR_W-1:0]           paddr,
    input  wire [rmsb_pkg::DATA_W-1:0]           pwdata,
    output logic [rmsb_pkg::DATA_W-1:0]          prdata,
    output logic                                 pready
);

    import rmsb_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_ACC  = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_SQRT = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(FIFO_SAMPLES - 3);
    localparam t_idx             DISCARD  = IDX_W'(DISCARD_VALUES);
    localparam t_idx             END_MAX  = IDX_W'(DISCARD_VALUES + 3 * (FIFO_SAMPLES - 3));

    logic [2:0]         r_state, n_state;
    logic [CNT_W-1:0]   r_sample_count;
    t_sum               r_sum, n_sum;
    t_idx               r_index, n_index;
    logic [MAG_W-1:0]   r_mag, n_mag;
    logic               r_keep, n_keep;
    logic               r_last, n_last;
    logic [N3_W-1:0]    r_n3, n_n3;
    logic [REM_W-1:0]   r_rem, n_rem;
    logic [ROOT_W-1:0]  r_root, n_root;
    logic [STEP_W-1:0]  r_step, n_step;
    logic               r_out_valid, n_out_valid;
    logic [RMS_W-1:0]   r_rms, n_rms;

    logic [CNT_W-1:0]   eff_count;
    logic [N3_W-1:0]    n3_cur;
    t_idx               end_cur;
    t_idx               idx_base;
    t_idx               idx_inc;
    logic [MAG_W-1:0]   mag_in;
    logic [2*MAG_W-1:0] square;
    t_alu               alu_a, alu_b, alu_diff;
    logic               alu_borrow;
    logic               alu_ge;
    logic               accept;
    logic               cfg_write;
    logic               out_free;

    // Configuration register
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr == ADDR_SAMPLE_COUNT);
    assign prdata    = (paddr == ADDR_SAMPLE_COUNT) ? DATA_W'(r_sample_count) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_count <= SAMPLE_COUNT_RST;
        end else if (cfg_write) begin
            r_sample_count <= pwdata[CNT_W-1:0];
        end
    end

    // Saturate the count and derive the burst length
    always_comb begin
        eff_count = r_sample_count;
        if (eff_count == '0) begin
            eff_count = CNT_W'(1);
        end
        if (eff_count > CNT_MAX) begin
            eff_count = CNT_MAX;
        end
        n3_cur  = (N3_W'(eff_count) << 1) + N3_W'(eff_count);
        end_cur = DISCARD + IDX_W'(n3_cur);
    end

    // Word position and magnitude at accept
    assign idx_base = i_burst_start ? '0 : r_index;
    assign idx_inc  = idx_base + IDX_W'(1);
    assign mag_in   = i_axis_value[AXIS_W-1] ? (MAG_W'(0) - MAG_W'(i_axis_value))
                                             : MAG_W'(i_axis_value);
    assign square   = r_mag * r_mag;

    // Shared subtract-and-compare unit
    always_comb begin
        alu_a = '0;
        alu_b = '0;
        if (r_state == S_DIV) begin
            alu_a = ALU_W'({r_rem[N3_W-1:0], r_sum[SUM_W-1]});
            alu_b = ALU_W'(r_n3);
        end else begin
            alu_a = {r_rem, r_sum[RAD_W-1 -: 2]};
            alu_b = ALU_W'({r_root, 2'b01});
        end
        {alu_borrow, alu_diff} = {1'b0, alu_a} - {1'b0, alu_b};
        alu_ge = !alu_borrow;
    end

    assign accept   = i_valid && o_ready;
    assign out_free = !r_out_valid || i_ready;

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_sum       = r_sum;
        n_index     = r_index;
        n_mag       = r_mag;
        n_keep      = r_keep;
        n_last      = r_last;
        n_n3        = r_n3;
        n_rem       = r_rem;
        n_root      = r_root;
        n_step      = r_step;
        n_rms       = r_rms;
        n_out_valid = r_out_valid && !i_ready;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_mag   = mag_in;
                    n_keep  = idx_base >= DISCARD;
                    n_last  = idx_inc >= end_cur;
                    n_index = (idx_inc >= end_cur) ? '0 : idx_inc;
                    n_n3    = n3_cur;
                    if (i_burst_start) begin
                        n_sum = '0;
                    end
                    n_state = S_ACC;
                end
            end
            S_ACC: begin
                // add the square of a kept word, then divide if the burst is complete
                if (r_keep) begin
                    n_sum = r_sum + SUM_W'(square);
                end
                n_rem  = '0;
                n_step = '0;
                n_state = r_last ? S_DIV : S_IDLE;
            end
            S_DIV: begin
                // one restoring divide step; quotient shifts into the low end
                n_rem  = alu_ge ? REM_W'(alu_diff[N3_W-1:0])
                                : REM_W'(alu_a[N3_W-1:0]);
                n_sum  = {r_sum[SUM_W-2:0], alu_ge};
                n_step = r_step + STEP_W'(1);
                if (r_step == DIV_LAST) begin
                    n_rem   = '0;
                    n_root  = '0;
                    n_step  = '0;
                    n_state = S_SQRT;
                end
            end
            S_SQRT: begin
                // one root digit per cycle from the top two radicand bits
                n_rem  = alu_ge ? alu_diff[REM_W-1:0] : alu_a[REM_W-1:0];
                n_root = {r_root[ROOT_W-2:0], alu_ge};
                n_sum  = {r_sum[SUM_W-3:0], 2'b00};
                n_step = r_step + STEP_W'(1);
                if (r_step == SQRT_LAST) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // hand the saturated root to the output register and rearm
                if (out_free) begin
                    n_rms       = r_root[ROOT_W-1] ? '1 : r_root[RMS_W-1:0];
                    n_out_valid = 1'b1;
                    n_sum       = '0;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sum       <= '0;
            r_index     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sum       <= n_sum;
            r_index     <= n_index;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mag  <= n_mag;
        r_keep <= n_keep;
        r_last <= n_last;
        r_n3   <= n_n3;
        r_rem  <= n_rem;
        r_root <= n_root;
        r_step <= n_step;
        r_rms  <= n_rms;
    end

    assign o_ready     = (r_state == S_IDLE);
    assign o_valid     = r_out_valid;
    assign o_rms_value = r_rms;

    // Checks
    a_index_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_index < END_MAX)
        else $error("word position ran past the longest burst");

    a_sum_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && out_free) |=> (r_sum == '0 && r_index == '0 && o_valid))
        else $error("burst state not cleared after result");

    a_sqrt_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SQRT) |-> (r_step <= SQRT_LAST))
        else $error("square root step count overrun");

    a_div_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && $past(r_state) != S_DIV) |-> (r_step == '0 && $past(r_last)))
        else $error("divide started without a completed burst");

endmodule

`default_nettype wire

### dv/testbench.sv
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import rmsb_pkg::*;

    localparam int FIFO_DEPTH  = 32;
    localparam int DISCARD     = 9;
    localparam int RMS_MAX     = 32767;
    localparam int TAIL_CYCLES = 100;
    localparam int HOLD_CYCLES = 600;
    localparam int LIMIT       = 1_000_000;

    typedef enum int {PACE_FULL, PACE_SENDER_IDLE, PACE_RECEIVER_STALL, PACE_BOTH} pace_t;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_valid = 1'b0;
    wire                      o_ready;
    logic signed [AXIS_W-1:0] i_axis_value = '0;
    logic                     i_burst_start = 1'b0;
    wire                      o_valid;
    logic                     i_ready = 1'b0;
    wire [RMS_W-1:0]          o_rms_value;
    logic                     psel = 1'b0;
    logic                     penable = 1'b0;
    logic                     pwrite = 1'b0;
    logic [ADDR_W-1:0]        paddr = '0;
    logic [DATA_W-1:0]        pwdata = '0;
    wire [DATA_W-1:0]         prdata;
    wire                      pready;

    // predictor state and configuration copy
    t_sum             acc_sum = '0;
    t_idx             word_pos = '0;
    logic [CNT_W-1:0] count_reg = SAMPLE_COUNT_RST;
    logic [RMS_W-1:0] rms_expected[$];

    int mismatches = 0;
    int results_seen = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_left = 0;
    logic [RMS_W-1:0] rms_want;

    rms_over_sample_burst #(
        .FIFO_SAMPLES(FIFO_DEPTH),
        .DISCARD_VALUES(DISCARD)
    ) u_top (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_ready(o_ready),
        .i_axis_value(i_axis_value),
        .i_burst_start(i_burst_start),
        .o_valid(o_valid),
        .i_ready(i_ready),
        .o_rms_value(o_rms_value),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // bound the run
    initial begin
        repeat (LIMIT) @(posedge i_clk);
        $display("simulation failed");
        $finish;
    end

    task automatic report_mismatch(input string what, input longint want, input longint got);
        $display("mismatch: %s: expected %0d, got %0d at %0t", what, want, got, $realtime);
        mismatches++;
    endtask

    function automatic int eff_count(input logic [CNT_W-1:0] c);
        if (c == 0) return 1;
        if (c > FIFO_DEPTH - 3) return FIFO_DEPTH - 3;
        return int'(c);
    endfunction

    function automatic logic [16:0] int_root(input t_sum x);
        logic [16:0] r;
        logic [63:0] sq;
        r = '0;
        for (int b = 16; b >= 0; b--) begin
            r[b] = 1'b1;
            sq = 64'(r) * 64'(r);
            if (sq > 64'(x)) r[b] = 1'b0;
        end
        return r;
    endfunction

    // advance the burst state by one accepted word, queue the RMS when the burst ends
    function automatic void predict_word(input logic signed [AXIS_W-1:0] v, input logic st);
        logic [MAG_W-1:0] mag;
        logic [N3_W-1:0]  n3;
        t_sum             mean;
        logic [16:0]      root;
        if (st) begin
            acc_sum = '0;
            word_pos = '0;
        end
        n3 = N3_W'(3 * eff_count(count_reg));
        if (word_pos >= DISCARD) begin
            mag = (v < 0) ? MAG_W'(-int'(v)) : MAG_W'(v);
            acc_sum = acc_sum + t_sum'(mag) * t_sum'(mag);
        end
        word_pos = word_pos + 1'b1;
        if (int'(word_pos) >= DISCARD + int'(n3)) begin
            mean = acc_sum / t_sum'(n3);
            root = int_root(mean);
            if (root > RMS_MAX) root = 17'(RMS_MAX);
            rms_expected.push_back(RMS_W'(root));
            acc_sum = '0;
            word_pos = '0;
        end
    endfunction

    function automatic logic signed [AXIS_W-1:0] pick_value();
        if ($urandom_range(0, 7) == 0) begin
            case ($urandom_range(0, 4))
                0: return -16'sd32768;
                1: return 16'sd32767;
                2: return 16'sd0;
                3: return -16'sd1;
                default: return 16'sd1;
            endcase
        end
        return AXIS_W'($urandom);
    endfunction

    function automatic void set_pace(input pace_t p);
        send_idle_pct  = (p == PACE_SENDER_IDLE) ? 84 : (p == PACE_BOTH) ? 14 : 0;
        recv_stall_pct = (p == PACE_RECEIVER_STALL) ? 84 : (p == PACE_BOTH) ? 14 : 0;
    endfunction

    // offer one word, hold it until accepted
    task automatic send_word(input logic signed [AXIS_W-1:0] v, input logic st);
        int gap;
        gap = 0;
        while (gap < 40 && $urandom_range(0, 99) < send_idle_pct) gap++;
        if (gap > 0) begin
            @(negedge i_clk) i_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_axis_value <= v;
        i_burst_start <= st;
        do @(posedge i_clk); while (!o_ready);
        predict_word(v, st);
    endtask

    // drop valid, wait out every pending result and the block's compute latency
    task automatic wait_idle();
        @(negedge i_clk) i_valid <= 1'b0;
        while (rms_expected.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_access(input logic wr, input logic [DATA_W-1:0] wd,
                              output logic [DATA_W-1:0] rd);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= ADDR_SAMPLE_COUNT;
        pwdata <= wd;
        @(negedge i_clk) penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rd = prdata;
        if (wr) count_reg = wd[CNT_W-1:0];
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // write sample_count once idle, then read it back
    task automatic write_count(input int value);
        logic [DATA_W-1:0] wd;
        logic [DATA_W-1:0] rd;
        wait_idle();
        wd = $urandom;
        wd[CNT_W-1:0] = CNT_W'(value);
        apb_access(1'b1, wd, rd);
        apb_access(1'b0, '0, rd);
        if (rd[CNT_W-1:0] !== CNT_W'(value))
            report_mismatch("sample_count readback", value, rd[CNT_W-1:0]);
    endtask

    // monitor: compare each accepted result with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            results_seen++;
            if (rms_expected.size() == 0) begin
                report_mismatch("rms_value with nothing expected", -1, o_rms_value);
            end else begin
                rms_want = rms_expected.pop_front();
                if (o_rms_value !== rms_want)
                    report_mismatch("rms_value", rms_want, o_rms_value);
            end
        end
    end

    // receiver: long hold-off when asked, random stalls otherwise
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_ready <= 1'b0;
            hold_left = hold_left - 1;
        end else begin
            i_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    task automatic test_reset_value();
        logic [DATA_W-1:0] rd;
        apb_access(1'b0, '0, rd);
        if (rd[CNT_W-1:0] !== SAMPLE_COUNT_RST)
            report_mismatch("sample_count after reset", SAMPLE_COUNT_RST, rd[CNT_W-1:0]);
    endtask

    // count 0 acts as 1; discarded extremes must not count; all -32768 saturates
    task automatic test_saturation();
        set_pace(PACE_FULL);
        write_count(0);
        send_word(16'sd32767, 1'b1);
        send_word(-16'sd32768, 1'b0);
        send_word(16'sd0, 1'b0);
        send_word(-16'sd1, 1'b0);
        for (int i = 0; i < 5; i++) send_word(pick_value(), 1'b0);
        for (int i = 0; i < 3; i++) send_word(-16'sd32768, 1'b0);
    endtask

    // start flag mid-burst resyncs; a count lowered mid-burst ends it at the new length
    task automatic test_resync_and_count_change();
        set_pace(PACE_FULL);
        write_count(30);
        send_word(pick_value(), 1'b0);
        send_word(pick_value(), 1'b0);
        send_word(16'sd100, 1'b1);
        for (int i = 0; i < 8; i++) send_word(pick_value(), 1'b0);
        send_word(16'sd32767, 1'b0);
        send_word(-16'sd5, 1'b0);
        write_count(1);
        send_word(16'sd1234, 1'b0);
    endtask

    // random bursts: mostly well formed, some unflagged, truncated or noise
    task automatic test_random_traffic(input pace_t p, input int cnt, input int n_words,
                                       input int min_results);
        int sent;
        int base;
        int kind;
        int len;
        int stop;
        set_pace(p);
        if (cnt >= 0) write_count(cnt);
        sent = 0;
        base = results_seen;
        while (sent < n_words || results_seen - base < min_results) begin
            kind = $urandom_range(0, 99);
            stop = DISCARD + 3 * eff_count(count_reg);
            if (kind < 70) begin
                len = stop;
                for (int i = 0; i < len; i++) send_word(pick_value(), i == 0);
            end else if (kind < 82) begin
                len = stop;
                for (int i = 0; i < len; i++) send_word(pick_value(), 1'b0);
            end else if (kind < 94) begin
                len = $urandom_range(1, stop - 1);
                for (int i = 0; i < len; i++) send_word(pick_value(), i == 0);
            end else begin
                len = $urandom_range(1, 4);
                for (int i = 0; i < len; i++)
                    send_word(pick_value(), $urandom_range(0, 3) == 0);
            end
            sent += len;
        end
    endtask

    // stall the receiver long enough to fill the block, then add random sender pauses and receiver stalls
    task automatic test_backpressure();
        set_pace(PACE_FULL);
        write_count(1);
        @(posedge i_clk);
        hold_left = HOLD_CYCLES;
        for (int b = 0; b < 4; b++)
            for (int i = 0; i < DISCARD + 3; i++) send_word(pick_value(), i == 0);
        wait_idle();
        set_pace(PACE_BOTH);
        for (int b = 0; b < 3; b++)
            for (int i = 0; i < DISCARD + 3; i++) send_word(pick_value(), i == 0);
    endtask

    initial begin
        int counts[8];
        counts = '{16, 2, 29, 1, 4, 31, 3, 0};
        counts[7] = $urandom_range(0, 31);

        // hold reset, then release it at a falling clock edge
        repeat (10) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        test_reset_value();
        test_saturation();
        test_resync_and_count_change();
        for (int k = 0; k < 8; k++)
            test_random_traffic(pace_t'(k / 2), counts[k], 110, 1);
        test_backpressure();

        wait_idle();
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
